FILE: src/i2cbe_pkg.sv
// Shared definitions for the I2C master bit engine: field widths, op codes and
// default timing constants. No dependencies.

package i2cbe_pkg;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DELAY_W = 16;

	// Command op codes carried on the request channel
	localparam logic [OP_W-1:0] OP_START    = 3'd0;
	localparam logic [OP_W-1:0] OP_STOP     = 3'd1;
	localparam logic [OP_W-1:0] OP_WRITE    = 3'd2;
	localparam logic [OP_W-1:0] OP_WAIT_ACK = 3'd3;
	localparam logic [OP_W-1:0] OP_READ     = 3'd4;

	localparam logic [DELAY_W-1:0] HALF_PERIOD_RST = 16'd5;

	localparam int unsigned READ_LEAD_TICKS_DEF = 30;
	localparam int unsigned ACK_POLL_LIMIT_DEF  = 253;
	localparam int unsigned EXTRA_TICKS_DEF     = 2;

endpackage

FILE: src/i2cbe_cmd_if.sv
// Tick/command request channel of the I2C master bit engine.
// Depends on i2cbe_pkg for field widths.

interface i2cbe_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd_valid;
	logic [i2cbe_pkg::OP_W-1:0]    op;
	logic [i2cbe_pkg::BYTE_W-1:0]  tx_byte;
	logic                          send_ack;
	logic                          sda_in;

	modport source (output valid, cmd_valid, op, tx_byte, send_ack, sda_in, input ready);
	modport sink   (input valid, cmd_valid, op, tx_byte, send_ack, sda_in, output ready);
endinterface

FILE: src/i2cbe_res_if.sv
// Result channel of the I2C master bit engine: line levels and status per tick.
// Depends on i2cbe_pkg for field widths.

interface i2cbe_res_if;
	logic                          valid;
	logic                          ready;
	logic                          scl_out;
	logic                          sda_out;
	logic                          sda_drive;
	logic                          busy_res;
	logic                          done_res;
	logic [i2cbe_pkg::BYTE_W-1:0]  rx_byte;
	logic                          ack_failed;

	modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
		ack_failed, input ready);
	modport sink   (input valid, scl_out, sda_out, sda_drive, busy_res, done_res, rx_byte,
		ack_failed, output ready);
endinterface

FILE: src/i2c_master_bit_engine_unit.sv
// Top level of the I2C master bit engine: input register, bit sequencer, result register.
// Depends on i2cbe_pkg, i2cbe_cmd_if and i2cbe_res_if.
//
//  channel  | kind        | direction | moves
//  ---------+-------------+-----------+----------------------------------------------
//  cmd      | valid/ready | sink      | one timing tick per request, maybe a command
//  res      | valid/ready | source    | one result per tick: SCL/SDA levels, status
//  cfg      | write only  | sink      | half_period, taken on any edge with cfg_wr_en
//
// One request per clock sustained while res is not stalled; a request passes through the
// input register, then the sequencer step lands in the result register. Throughput is set by the single
// sequencer step per tick, which depends on the state left by the previous tick.
// Reset (arst_n low) returns to idle, SCL and SDA high and driven, half_period 5.
// A stall on res holds the result register; the input register then fills and
// cmd.ready drops until the result is taken.

module i2c_master_bit_engine_unit #(
	parameter int unsigned READ_LEAD_TICKS = i2cbe_pkg::READ_LEAD_TICKS_DEF,
	parameter int unsigned ACK_POLL_LIMIT  = i2cbe_pkg::ACK_POLL_LIMIT_DEF,
	parameter int unsigned EXTRA_TICKS     = i2cbe_pkg::EXTRA_TICKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	i2cbe_cmd_if.sink                        cmd,
	i2cbe_res_if.source                      res,
	input  logic                             cfg_wr_en,
	input  logic [i2cbe_pkg::DELAY_W-1:0]    cfg_wr_data
);

	localparam int unsigned DW = i2cbe_pkg::DELAY_W;
	localparam int unsigned BW = i2cbe_pkg::BYTE_W;

	// Sequencer phases
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_ST_LOW, PH_ST_END,
		PH_SP_END,
		PH_WR_LO, PH_WR_HI, PH_WR_TAIL, PH_WR_END,
		PH_RD_LO, PH_RD_HI, PH_RD_ACK_LO, PH_RD_ACK_HI, PH_RD_ACK_END,
		PH_WA_SCL, PH_WA_POLL, PH_WA_STOP_END
	} phase_t;

	// Delay loads are clamped to 1..65535 ticks
	function automatic logic [DW-1:0] clamp_delay(input logic [DW:0] d);
		logic [DW-1:0] r;
		if (d == '0)
			r = {{(DW-1){1'b0}}, 1'b1};
		else if (d[DW])
			r = '1;
		else
			r = d[DW-1:0];
		return r;
	endfunction

	// Config register
	logic [DW-1:0] half_period_q;

	// Input register
	logic            vld_s1;
	logic            cmd_valid_s1;
	logic [2:0]      op_s1;
	logic [BW-1:0]   tx_byte_s1;
	logic            send_ack_s1;
	logic            sda_in_s1;

	// Sequencer state
	phase_t          ph_q;
	logic [DW-1:0]   dly_q;
	logic [3:0]      bit_q;
	logic [BW-1:0]   sh_q;
	logic [7:0]      poll_q;
	logic            ackc_q;
	logic            scl_q, sda_q, drv_q;
	logic            fail_q;
	logic [BW-1:0]   rx_q;

	// Result register
	logic            vld_s2;
	logic            scl_s2, sda_s2, drv_s2, busy_s2, done_s2, fail_s2;
	logic [BW-1:0]   rx_s2;

	// Next-state values
	phase_t          ph_n;
	logic [DW-1:0]   dly_n;
	logic [3:0]      bit_n;
	logic [BW-1:0]   sh_n;
	logic [7:0]      poll_n;
	logic            ackc_n;
	logic            scl_n, sda_n, drv_n;
	logic            fail_n;
	logic [BW-1:0]   rx_n;
	logic            done_n;

	logic            out_free;
	logic            step;
	logic [DW:0]     long_dly;
	logic [DW-1:0]   hp_dly;

	assign out_free  = !vld_s2 || res.ready;
	assign step      = vld_s1 && out_free;
	assign cmd.ready = !vld_s1 || out_free;

	assign long_dly = {1'b0, half_period_q} + (DW+1)'(EXTRA_TICKS);
	assign hp_dly   = clamp_delay({1'b0, half_period_q});

	// One sequencer step for the tick held in the input register
	always_comb begin
		ph_n   = ph_q;
		dly_n  = dly_q;
		bit_n  = bit_q;
		sh_n   = sh_q;
		poll_n = poll_q;
		ackc_n = ackc_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		drv_n  = drv_q;
		fail_n = fail_q;
		rx_n   = rx_q;
		done_n = 1'b0;

		if (ph_q == PH_IDLE) begin
			if (cmd_valid_s1) begin
				case (op_s1)
					i2cbe_pkg::OP_START: begin
						scl_n = 1'b1; sda_n = 1'b1; drv_n = 1'b1;
						dly_n = clamp_delay(long_dly);
						ph_n  = PH_ST_LOW;
					end
					i2cbe_pkg::OP_STOP: begin
						drv_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0;
						dly_n = clamp_delay(long_dly);
						ph_n  = PH_SP_END;
					end
					i2cbe_pkg::OP_WRITE: begin
						sh_n  = tx_byte_s1;
						bit_n = '0;
						scl_n = 1'b0; drv_n = 1'b1;
						dly_n = hp_dly;
						ph_n  = PH_WR_LO;
					end
					i2cbe_pkg::OP_WAIT_ACK: begin
						fail_n = 1'b0; poll_n = '0;
						drv_n  = 1'b0; sda_n = 1'b1;
						dly_n  = clamp_delay(long_dly);
						ph_n   = PH_WA_SCL;
					end
					i2cbe_pkg::OP_READ: begin
						ackc_n = send_ack_s1;
						sh_n   = '0;
						bit_n  = '0;
						dly_n  = clamp_delay((DW+1)'(READ_LEAD_TICKS));
						ph_n   = PH_RD_LO;
					end
					default: ;
				endcase
			end
		end else if (dly_q > {{(DW-1){1'b0}}, 1'b1}) begin
			dly_n = dly_q - DW'(1);
		end else begin
			case (ph_q)
				PH_ST_LOW: begin
					sda_n = 1'b0;
					dly_n = clamp_delay(long_dly);
					ph_n  = PH_ST_END;
				end
				PH_ST_END: begin
					scl_n = 1'b0; done_n = 1'b1;
				end
				PH_SP_END: begin
					scl_n = 1'b1; sda_n = 1'b1; done_n = 1'b1;
				end
				PH_WR_LO: begin
					scl_n = 1'b0; sda_n = sh_q[BW-1];
					dly_n = hp_dly;
					ph_n  = PH_WR_HI;
				end
				PH_WR_HI: begin
					scl_n = 1'b1;
					sh_n  = {sh_q[BW-2:0], 1'b0};
					bit_n = bit_q + 4'd1;
					dly_n = hp_dly;
					ph_n  = (bit_n < 4'd8) ? PH_WR_LO : PH_WR_TAIL;
				end
				PH_WR_TAIL: begin
					scl_n = 1'b0;
					dly_n = {{(DW-1){1'b0}}, 1'b1};
					ph_n  = PH_WR_END;
				end
				PH_WR_END: done_n = 1'b1;
				PH_RD_LO: begin
					scl_n = 1'b0; drv_n = 1'b0;
					dly_n = hp_dly;
					ph_n  = PH_RD_HI;
				end
				PH_RD_HI: begin
					scl_n = 1'b1;
					sh_n  = {sh_q[BW-2:0], sda_in_s1};
					bit_n = bit_q + 4'd1;
					dly_n = hp_dly;
					ph_n  = (bit_n < 4'd8) ? PH_RD_LO : PH_RD_ACK_LO;
				end
				PH_RD_ACK_LO: begin
					scl_n = 1'b0; drv_n = 1'b1; sda_n = !ackc_q;
					dly_n = ackc_q ? hp_dly : clamp_delay(long_dly);
					ph_n  = PH_RD_ACK_HI;
				end
				PH_RD_ACK_HI: begin
					scl_n = 1'b1;
					dly_n = ackc_q ? hp_dly : clamp_delay(long_dly);
					ph_n  = PH_RD_ACK_END;
				end
				PH_RD_ACK_END: begin
					scl_n = 1'b0; rx_n = sh_q; done_n = 1'b1;
				end
				PH_WA_SCL: begin
					scl_n = 1'b1;
					dly_n = clamp_delay(long_dly);
					ph_n  = PH_WA_POLL;
				end
				PH_WA_POLL: begin
					if (!sda_in_s1) begin
						scl_n = 1'b0; done_n = 1'b1;
					end else if (({1'b0, poll_q} + 9'd1) > 9'(ACK_POLL_LIMIT)) begin
						// timeout: send a stop and flag it at the end
						drv_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0;
						dly_n = clamp_delay(long_dly);
						ph_n  = PH_WA_STOP_END;
					end else begin
						poll_n = poll_q + 8'd1;
						dly_n  = {{(DW-1){1'b0}}, 1'b1};
					end
				end
				PH_WA_STOP_END: begin
					scl_n = 1'b1; sda_n = 1'b1; fail_n = 1'b1; done_n = 1'b1;
				end
				default: done_n = 1'b1;
			endcase
			if (done_n) begin
				ph_n  = PH_IDLE;
				dly_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q <= i2cbe_pkg::HALF_PERIOD_RST;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ph_q   <= PH_IDLE;
			dly_q  <= '0;
			bit_q  <= '0;
			sh_q   <= '0;
			poll_q <= '0;
			ackc_q <= 1'b0;
			scl_q  <= 1'b1;
			sda_q  <= 1'b1;
			drv_q  <= 1'b1;
			fail_q <= 1'b0;
			rx_q   <= '0;
		end else begin
			if (cfg_wr_en)
				half_period_q <= cfg_wr_data;

			if (cmd.valid && cmd.ready) begin
				vld_s1       <= 1'b1;
				cmd_valid_s1 <= cmd.cmd_valid;
				op_s1        <= cmd.op;
				tx_byte_s1   <= cmd.tx_byte;
				send_ack_s1  <= cmd.send_ack;
				sda_in_s1    <= cmd.sda_in;
			end else if (step) begin
				vld_s1 <= 1'b0;
			end

			if (step) begin
				ph_q   <= ph_n;
				dly_q  <= dly_n;
				bit_q  <= bit_n;
				sh_q   <= sh_n;
				poll_q <= poll_n;
				ackc_q <= ackc_n;
				scl_q  <= scl_n;
				sda_q  <= sda_n;
				drv_q  <= drv_n;
				fail_q <= fail_n;
				rx_q   <= rx_n;
				// result shows the state after this tick
				vld_s2  <= 1'b1;
				scl_s2  <= scl_n;
				sda_s2  <= sda_n;
				drv_s2  <= drv_n;
				busy_s2 <= (ph_n != PH_IDLE);
				done_s2 <= done_n;
				rx_s2   <= rx_n;
				fail_s2 <= fail_n;
			end else if (res.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	assign res.valid      = vld_s2;
	assign res.scl_out    = scl_s2;
	assign res.sda_out    = sda_s2;
	assign res.sda_drive  = drv_s2;
	assign res.busy_res   = busy_s2;
	assign res.done_res   = done_s2;
	assign res.rx_byte    = rx_s2;
	assign res.ack_failed = fail_s2;

endmodule

FILE: src/i2cbe_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends on i2cbe_pkg and i2c_master_bit_engine_unit.

module i2cbe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic                          busy_res,
	input logic                          done_res,
	input logic                          ack_failed,
	input logic [i2cbe_pkg::BYTE_W-1:0]  rx_byte
);

	logic res_acc;
	logic prev_busy_q;
	logic prev_fail_q;

	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_busy_q <= 1'b0;
			prev_fail_q <= 1'b0;
		end else if (res_acc) begin
			prev_busy_q <= busy_res;
			prev_fail_q <= ack_failed;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result withdrawn while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(rx_byte) && $stable(done_res))
		else $error("stalled result changed");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && done_res |-> prev_busy_q && !busy_res)
		else $error("done without a command in progress");

	a_fail_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && ack_failed && !prev_fail_q |-> done_res)
		else $error("ack failure raised outside command completion");

endmodule

bind i2c_master_bit_engine_unit i2cbe_checker u_i2cbe_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.busy_res   (res.busy_res),
	.done_res   (res.done_res),
	.ack_failed (res.ack_failed),
	.rx_byte    (res.rx_byte)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_master_bit_engine_unit: drives timing-tick requests and
// checks every per-tick result against a cycle-exact model of the SCL/SDA sequencer.
// Depends on i2cbe_pkg, i2cbe_cmd_if, i2cbe_res_if and the unit itself.

module tb;

	localparam int unsigned OW = i2cbe_pkg::OP_W;
	localparam int unsigned BW = i2cbe_pkg::BYTE_W;
	localparam int unsigned DW = i2cbe_pkg::DELAY_W;

	// Sequencer phases of the bus model; one command walks through a chain of them
	typedef enum logic [4:0] {
		SEQ_IDLE,
		SEQ_START_LOW, SEQ_START_END,
		SEQ_STOP_END,
		SEQ_WR_LOW, SEQ_WR_HIGH, SEQ_WR_TAIL, SEQ_WR_END,
		SEQ_RD_LOW, SEQ_RD_HIGH, SEQ_ACK_LOW, SEQ_ACK_HIGH, SEQ_ACK_END,
		SEQ_WAIT_SCL, SEQ_WAIT_POLL, SEQ_WAIT_STOP
	} seq_phase_t;

	// One timing tick as carried by a request on the cmd channel
	typedef struct packed {
		logic          cmd_valid;
		logic [OW-1:0] op;
		logic [BW-1:0] tx_byte;
		logic          send_ack;
		logic          sda_in;
	} tick_t;

	// Line levels and status after one tick, as carried on the res channel
	typedef struct packed {
		logic          scl;
		logic          sda;
		logic          drive;
		logic          busy;
		logic          done;
		logic [BW-1:0] rx;
		logic          ack_failed;
	} levels_t;

	localparam logic [OW-1:0] OP_TOP         = '1;       // highest op encoding, unused above read
	localparam int unsigned DELAY_MAX        = (1 << DW) - 1;
	localparam int unsigned SETTLE_CYCLES    = 4;        // margin after the last expected result
	localparam int unsigned HOLD_OFF_CYCLES  = 400;      // long receiver stall for back-pressure
	localparam int unsigned WATCHDOG_LIMIT   = 5000;     // cycles without any handshake

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic            cfg_wr_en;
	logic [DW-1:0]   cfg_wr_data;

	i2cbe_cmd_if cmd_if ();
	i2cbe_res_if res_if ();

	i2c_master_bit_engine_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_if),
		.res         (res_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Bus model state: own copy of half_period plus the sequencer state,
	// all at their reset values.
	// ------------------------------------------------------------------
	int unsigned       hp_ticks  = 32'(i2cbe_pkg::HALF_PERIOD_RST);
	seq_phase_t        seq       = SEQ_IDLE;
	int unsigned       dly       = 0;
	logic [3:0]        bit_idx   = '0;
	logic [BW-1:0]     shreg     = '0;
	int unsigned       polls     = 0;
	logic              ack_sel   = 1'b0;
	logic              scl_lv    = 1'b1;
	logic              sda_lv    = 1'b1;
	logic              drv_lv    = 1'b1;
	logic              fail_lv   = 1'b0;
	logic [BW-1:0]     rx_last   = '0;

	levels_t     levels_due[$];      // expected results, oldest first
	int unsigned level_mismatches = 0;
	int unsigned results_seen     = 0;
	int unsigned ticks_sent       = 0;
	int unsigned sda_hold         = 0;  // polls for which the slave keeps SDA high
	int unsigned hold_off_req     = 0;  // long receiver stall asked of the sink process
	bit          src_gaps_on      = 1'b0;
	bit          sink_stalls_on   = 1'b0;

	function automatic logic [BW-1:0] rand_byte();
		return BW'($urandom_range(0, 255));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Delays are clamped to 1..65535 ticks
	function automatic void load_delay(input int unsigned d);
		dly = (d == 0) ? 1 : ((d > DELAY_MAX) ? DELAY_MAX : d);
	endfunction

	function automatic int unsigned stretched_delay();
		return hp_ticks + i2cbe_pkg::EXTRA_TICKS_DEF;
	endfunction

	// Idle tick with cmd_valid set: load the first action of the command.
	// Unknown ops leave the sequencer idle.
	function automatic void open_command(input tick_t t);
		case (t.op)
		i2cbe_pkg::OP_START: begin
			scl_lv = 1'b1; sda_lv = 1'b1; drv_lv = 1'b1;
			load_delay(stretched_delay()); seq = SEQ_START_LOW;
		end
		i2cbe_pkg::OP_STOP: begin
			drv_lv = 1'b1; scl_lv = 1'b0; sda_lv = 1'b0;
			load_delay(stretched_delay()); seq = SEQ_STOP_END;
		end
		i2cbe_pkg::OP_WRITE: begin
			shreg = t.tx_byte; bit_idx = '0;
			scl_lv = 1'b0; drv_lv = 1'b1;
			load_delay(hp_ticks); seq = SEQ_WR_LOW;
		end
		i2cbe_pkg::OP_WAIT_ACK: begin
			fail_lv = 1'b0; polls = 0;
			drv_lv = 1'b0; sda_lv = 1'b1;
			load_delay(stretched_delay()); seq = SEQ_WAIT_SCL;
		end
		i2cbe_pkg::OP_READ: begin
			ack_sel = t.send_ack; shreg = '0; bit_idx = '0;
			load_delay(i2cbe_pkg::READ_LEAD_TICKS_DEF); seq = SEQ_RD_LOW;
		end
		default: ;
		endcase
	endfunction

	// Action at the end of a delay; returns 1 when the command completes
	function automatic logic phase_action(input logic sda_in);
		int unsigned ack_ticks;
		ack_ticks = ack_sel ? hp_ticks : stretched_delay();
		case (seq)
		SEQ_START_LOW: begin
			sda_lv = 1'b0; load_delay(stretched_delay()); seq = SEQ_START_END;
		end
		SEQ_START_END: begin
			scl_lv = 1'b0; return 1'b1;
		end
		SEQ_STOP_END: begin
			scl_lv = 1'b1; sda_lv = 1'b1; return 1'b1;
		end
		SEQ_WR_LOW: begin
			scl_lv = 1'b0; sda_lv = shreg[BW-1];
			load_delay(hp_ticks); seq = SEQ_WR_HIGH;
		end
		SEQ_WR_HIGH: begin
			scl_lv = 1'b1; shreg = shreg << 1; bit_idx = bit_idx + 4'd1;
			load_delay(hp_ticks);
			seq = (bit_idx < BW) ? SEQ_WR_LOW : SEQ_WR_TAIL;
		end
		SEQ_WR_TAIL: begin
			scl_lv = 1'b0; load_delay(1); seq = SEQ_WR_END;
		end
		SEQ_WR_END: return 1'b1;
		SEQ_RD_LOW: begin
			scl_lv = 1'b0; drv_lv = 1'b0;
			load_delay(hp_ticks); seq = SEQ_RD_HIGH;
		end
		SEQ_RD_HIGH: begin
			scl_lv = 1'b1; shreg = {shreg[BW-2:0], sda_in}; bit_idx = bit_idx + 4'd1;
			load_delay(hp_ticks);
			seq = (bit_idx < BW) ? SEQ_RD_LOW : SEQ_ACK_LOW;
		end
		SEQ_ACK_LOW: begin
			scl_lv = 1'b0; drv_lv = 1'b1; sda_lv = ~ack_sel;
			load_delay(ack_ticks); seq = SEQ_ACK_HIGH;
		end
		SEQ_ACK_HIGH: begin
			scl_lv = 1'b1; load_delay(ack_ticks); seq = SEQ_ACK_END;
		end
		SEQ_ACK_END: begin
			scl_lv = 1'b0; rx_last = shreg; return 1'b1;
		end
		SEQ_WAIT_SCL: begin
			scl_lv = 1'b1; load_delay(stretched_delay()); seq = SEQ_WAIT_POLL;
		end
		SEQ_WAIT_POLL: begin
			if (!sda_in) begin
				scl_lv = 1'b0;
				return 1'b1;
			end
			if (polls + 1 > i2cbe_pkg::ACK_POLL_LIMIT_DEF) begin
				// no acknowledge in time: issue a stop
				drv_lv = 1'b1; scl_lv = 1'b0; sda_lv = 1'b0;
				load_delay(stretched_delay()); seq = SEQ_WAIT_STOP;
			end else begin
				polls++;
				load_delay(1);
			end
		end
		SEQ_WAIT_STOP: begin
			scl_lv = 1'b1; sda_lv = 1'b1; fail_lv = 1'b1; return 1'b1;
		end
		default: return 1'b1;
		endcase
		return 1'b0;
	endfunction

	// Advance the bus model by one tick and return the levels it leaves
	function automatic levels_t bus_levels_after(input tick_t t);
		levels_t r;
		logic    fin;
		fin = 1'b0;
		if (seq == SEQ_IDLE) begin
			if (t.cmd_valid) open_command(t);
		end else if (dly > 1) begin
			dly--;
		end else begin
			fin = phase_action(t.sda_in);
			if (fin) begin
				seq = SEQ_IDLE;
				dly = 0;
			end
		end
		r.scl        = scl_lv;
		r.sda        = sda_lv;
		r.drive      = drv_lv;
		r.busy       = (seq != SEQ_IDLE);
		r.done       = fin;
		r.rx         = rx_last;
		r.ack_failed = fail_lv;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Called at a rising edge; returns at the edge where the
	// request was taken, with the expectation already queued.
	// ------------------------------------------------------------------
	task automatic send_tick(input tick_t t);
		if (src_gaps_on && $urandom_range(0, 11) == 0) begin
			cmd_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.cmd_valid <= t.cmd_valid;
		cmd_if.op        <= t.op;
		cmd_if.tx_byte   <= t.tx_byte;
		cmd_if.send_ack  <= t.send_ack;
		cmd_if.sda_in    <= t.sda_in;
		@(posedge clk);
		while (cmd_if.ready !== 1'b1) @(posedge clk);
		levels_due.push_back(bus_levels_after(t));
		ticks_sent++;
	endtask

	task automatic idle_ticks(input int unsigned n);
		tick_t t;
		repeat (n) begin
			t           = tick_t'($urandom);
			t.cmd_valid = 1'b0;
			send_tick(t);
		end
	endtask

	// Issue one command and keep ticking until the model is idle again.
	// Ticks while busy carry random noise, which the block must ignore.
	// SDA plays the slave: random data during a read, and during an ack
	// wait it stays high for 'hold' polls before being pulled low.
	task automatic run_command(input logic [OW-1:0] op, input logic [BW-1:0] tx,
			input logic ack, input int unsigned hold);
		tick_t t;
		sda_hold    = hold;
		t           = tick_t'($urandom);
		t.cmd_valid = 1'b1;
		t.op        = op;
		t.tx_byte   = tx;
		t.send_ack  = ack;
		send_tick(t);
		while (seq != SEQ_IDLE) begin
			t = tick_t'($urandom);
			if (seq == SEQ_WAIT_POLL && dly <= 1) begin
				t.sda_in = (sda_hold != 0);
				if (sda_hold != 0) sda_hold--;
			end
			send_tick(t);
		end
	endtask

	// Mostly a prompt acknowledge; now and then the last possible poll, or none
	function automatic int unsigned random_ack_hold();
		case ($urandom_range(0, 19))
		0:       return $urandom_range(i2cbe_pkg::ACK_POLL_LIMIT_DEF + 1,
				i2cbe_pkg::ACK_POLL_LIMIT_DEF + 40);
		1:       return i2cbe_pkg::ACK_POLL_LIMIT_DEF;
		default: return $urandom_range(0, 12);
		endcase
	endfunction

	// A well-formed bus transfer: start, address, ack, a data byte or two, stop
	task automatic run_transfer();
		int unsigned n_parts;
		n_parts = $urandom_range(1, 2);
		run_command(i2cbe_pkg::OP_START, rand_byte(), rand_bit(), 0);
		run_command(i2cbe_pkg::OP_WRITE, rand_byte(), rand_bit(), 0);
		run_command(i2cbe_pkg::OP_WAIT_ACK, rand_byte(), rand_bit(), random_ack_hold());
		repeat (n_parts) begin
			if (rand_bit()) begin
				run_command(i2cbe_pkg::OP_WRITE, rand_byte(), rand_bit(), 0);
				run_command(i2cbe_pkg::OP_WAIT_ACK, rand_byte(), rand_bit(),
					random_ack_hold());
			end else begin
				run_command(i2cbe_pkg::OP_READ, rand_byte(), rand_bit(), 0);
			end
		end
		run_command(i2cbe_pkg::OP_STOP, rand_byte(), rand_bit(), 0);
	endtask

	// Mix of whole transfers, lone commands (broken sequences), bad ops and idle ticks
	task automatic random_traffic(input int unsigned n);
		int unsigned target;
		int unsigned pick;
		target = ticks_sent + n;
		while (ticks_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 13)
				run_transfer();
			else if (pick < 17)
				run_command(OW'($urandom_range(i2cbe_pkg::OP_START, i2cbe_pkg::OP_READ)),
					rand_byte(), rand_bit(), random_ack_hold());
			else if (pick < 18)
				run_command(OW'($urandom_range(i2cbe_pkg::OP_READ + 1, OP_TOP)),
					rand_byte(), rand_bit(), 0);
			else
				idle_ticks($urandom_range(1, 6));
		end
	endtask

	// Stop offering requests and wait until every expected result is in
	task automatic settle_bus();
		cmd_if.valid <= 1'b0;
		while (levels_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// half_period is only rewritten with the pipeline empty
	task automatic set_half_period(input int unsigned v);
		settle_bus();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= DW'(v);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		hp_ticks    = v;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Levels straight after reset, then a short transfer at the default half period
	task automatic test_reset_defaults();
		idle_ticks(4);
		run_command(i2cbe_pkg::OP_START, 8'h00, 1'b0, 0);
		run_command(i2cbe_pkg::OP_WRITE, 8'h5a, 1'b0, 0);
		run_command(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 0);
	endtask

	// Each op at the fastest setting, byte extremes, ack boundaries, bad ops
	task automatic test_each_command();
		set_half_period(1);
		run_command(i2cbe_pkg::OP_START, 8'h00, 1'b0, 0);
		run_command(i2cbe_pkg::OP_WRITE, 8'h00, 1'b0, 0);
		run_command(i2cbe_pkg::OP_WRITE, 8'hff, 1'b1, 0);
		run_command(i2cbe_pkg::OP_WRITE, 8'ha5, 1'b0, 0);
		// ack on first poll, on last poll, then timeout with a stop sent
		run_command(i2cbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, 0);
		run_command(i2cbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0, i2cbe_pkg::ACK_POLL_LIMIT_DEF);
		run_command(i2cbe_pkg::OP_WAIT_ACK, 8'h00, 1'b0,
			i2cbe_pkg::ACK_POLL_LIMIT_DEF + 1);
		run_command(i2cbe_pkg::OP_READ, 8'h00, 1'b1, 0);   // read then ACK
		run_command(i2cbe_pkg::OP_READ, 8'hff, 1'b0, 0);   // read then NACK
		for (int o = i2cbe_pkg::OP_READ + 1; o <= OP_TOP; o++)
			run_command(OW'(o), 8'h00, 1'b1, 0);
		run_command(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 0);
	endtask

	// Random traffic over small half periods, idling on and off per phase
	task automatic test_random_traffic();
		repeat (2) begin
			set_half_period($urandom_range(1, 6));
			src_gaps_on    = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			random_traffic(150);
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming: the
	// result register and input register fill and cmd.ready must drop
	task automatic test_back_pressure();
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		hold_off_req   = HOLD_OFF_CYCLES;
		run_transfer();
	endtask

	// A slower setting: long phase delays counted down tick by tick
	task automatic test_slow_bus();
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		set_half_period(60);
		run_command(i2cbe_pkg::OP_START, 8'h00, 1'b0, 0);
		run_command(i2cbe_pkg::OP_STOP, 8'h00, 1'b0, 0);
	endtask

	// Back-to-back requests and results with no idling on either side
	task automatic test_steady_stream();
		set_half_period(2);
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		random_traffic(120);
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset once, then the tests in turn
	// ------------------------------------------------------------------
	initial begin
		cmd_if.valid     <= 1'b0;
		cmd_if.cmd_valid <= 1'b0;
		cmd_if.op        <= i2cbe_pkg::OP_START;
		cmd_if.tx_byte   <= '0;
		cmd_if.send_ack  <= 1'b0;
		cmd_if.sda_in    <= 1'b1;
		cfg_wr_en        <= 1'b0;
		cfg_wr_data      <= i2cbe_pkg::HALF_PERIOD_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_each_command();
		test_random_traffic();
		test_back_pressure();
		test_slow_bus();
		test_steady_stream();

		settle_bus();
		if (level_mismatches == 0 && levels_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result sink: random stall bursts, plus one long hold-off on request,
	// counted here so the sender keeps pushing meanwhile
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		res_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req != 0) begin
				stall_left   = hold_off_req;
				hold_off_req = 0;
			end
			if (stall_left != 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else if (sink_stalls_on && $urandom_range(0, 11) == 0) begin
				res_if.ready <= 1'b0;
				stall_left   = $urandom_range(1, 13) - 1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	task automatic compare_field(input string fname, input logic [BW-1:0] want,
			input logic [BW-1:0] got);
		if (got !== want) begin
			level_mismatches++;
			if (level_mismatches <= 10)
				$display("result %0d: %s expected %0h, got %0h", results_seen, fname, want,
					got);
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		levels_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (levels_due.size() == 0) begin
				level_mismatches++;
				if (level_mismatches <= 10)
					$display("result %0d arrived with no request outstanding", results_seen);
			end else begin
				want = levels_due.pop_front();
				compare_field("scl_out", BW'(want.scl), BW'(res_if.scl_out));
				compare_field("sda_out", BW'(want.sda), BW'(res_if.sda_out));
				compare_field("sda_drive", BW'(want.drive), BW'(res_if.sda_drive));
				compare_field("busy_res", BW'(want.busy), BW'(res_if.busy_res));
				compare_field("done_res", BW'(want.done), BW'(res_if.done_res));
				compare_field("rx_byte", want.rx, res_if.rx_byte);
				compare_field("ack_failed", BW'(want.ack_failed), BW'(res_if.ack_failed));
			end
			results_seen++;
		end
	end

	// Watchdog: any handshake on either channel counts as progress
	always @(posedge clk) begin : watchdog
		int unsigned quiet_cycles;
		if (!arst_n || (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
				(res_if.valid === 1'b1 && res_if.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
